// ----- sv/source_text_lexer_macros.svh -----
// Assertion helpers for the checker file
`ifndef SOURCE_TEXT_LEXER_MACROS_SVH
`define SOURCE_TEXT_LEXER_MACROS_SVH

// Check a property at every clock edge outside reset
`define STL_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the next cycle
`define STL_ASSERT_NEXT(lbl, clk, rst_n, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) else $error(msg);

`endif

// ----- sv/stl_pkg.sv -----
`timescale 1ns / 1ps
package stl_pkg;

	// Token kinds
	localparam logic [5:0] TK_NAME = 6'd0;
	localparam logic [5:0] TK_STR = 6'd1;
	localparam logic [5:0] TK_UNDER = 6'd2;
	localparam logic [5:0] TK_HEX = 6'd3;
	localparam logic [5:0] TK_BIN = 6'd4;
	localparam logic [5:0] TK_DEC = 6'd5;
	localparam logic [5:0] TK_FLT = 6'd6;
	localparam logic [5:0] TK_EXP = 6'd7;
	localparam logic [5:0] TK_LPAR = 6'd8;
	localparam logic [5:0] TK_RPAR = 6'd9;
	localparam logic [5:0] TK_LBRK = 6'd10;
	localparam logic [5:0] TK_RBRK = 6'd11;
	localparam logic [5:0] TK_LBRC = 6'd12;
	localparam logic [5:0] TK_RBRC = 6'd13;
	localparam logic [5:0] TK_ADD = 6'd14;
	localparam logic [5:0] TK_ARW = 6'd15;
	localparam logic [5:0] TK_SUB = 6'd16;
	localparam logic [5:0] TK_MUL = 6'd17;
	localparam logic [5:0] TK_DIV = 6'd18;
	localparam logic [5:0] TK_HSH = 6'd19;
	localparam logic [5:0] TK_ATS = 6'd20;
	localparam logic [5:0] TK_TLD = 6'd21;
	localparam logic [5:0] TK_NE = 6'd22;
	localparam logic [5:0] TK_BANG = 6'd23;
	localparam logic [5:0] TK_QM = 6'd24;
	localparam logic [5:0] TK_COL = 6'd25;
	localparam logic [5:0] TK_SEMI = 6'd26;
	localparam logic [5:0] TK_CMA = 6'd27;
	localparam logic [5:0] TK_ELL = 6'd28;
	localparam logic [5:0] TK_DOT = 6'd29;
	localparam logic [5:0] TK_ERR = 6'd30;
	localparam logic [5:0] TK_CHR = 6'd31;
	localparam logic [5:0] TK_AMP = 6'd32;
	localparam logic [5:0] TK_BAR = 6'd33;
	localparam logic [5:0] TK_CRT = 6'd34;
	localparam logic [5:0] TK_EQ = 6'd35;
	localparam logic [5:0] TK_ASN = 6'd36;
	localparam logic [5:0] TK_GE = 6'd37;
	localparam logic [5:0] TK_ROR = 6'd38;
	localparam logic [5:0] TK_SHR = 6'd39;
	localparam logic [5:0] TK_GT = 6'd40;
	localparam logic [5:0] TK_LE = 6'd41;
	localparam logic [5:0] TK_ROL = 6'd42;
	localparam logic [5:0] TK_SHL = 6'd43;
	localparam logic [5:0] TK_LT = 6'd44;
	localparam logic [5:0] TK_END = 6'd45;

	// Characters
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_NL = 8'h0A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_UND = 8'h5F;
	localparam logic [7:0] CH_X = 8'h78;
	localparam logic [7:0] CH_B = 8'h62;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_E = 8'h65;
	localparam logic [7:0] CH_UE = 8'h45;
	localparam logic [7:0] CH_DQ = 8'h22;
	localparam logic [7:0] CH_SQ = 8'h27;
	localparam logic [7:0] CH_BSL = 8'h5C;
	localparam logic [7:0] CH_GT = 8'h3E;
	localparam logic [7:0] CH_LT = 8'h3C;
	localparam logic [7:0] CH_EQ = 8'h3D;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_ONE = 8'h31;

	typedef enum logic [3:0] {
		M_IDLE, M_LINE, M_BLOCK, M_BLOCK_SKIP, M_SKIP1, M_SKIP2, M_SKIP3,
		M_IDENT, M_PREFIX, M_RADIX, M_DEC, M_DEC_MARK, M_STRING
	} mode_t;

	// What the lexer core does in a cycle
	typedef enum logic [1:0] {
		OP_NONE,
		OP_STEP,
		OP_DRAIN,
		OP_TAIL
	} op_t;

	typedef struct packed {
		logic [5:0]  kind;
		logic [15:0] start;
		logic [15:0] len;
		logic [15:0] line;
		logic [15:0] col;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [5:0] kind;
		logic [2:0] len;
	} fix_t;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return is_alpha(c) || is_digit(c);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic is_xdigit(input logic [7:0] c);
		return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
	endfunction

	function automatic logic ident_char(input logic [7:0] c);
		return is_alnum(c) || c == CH_UND;
	endfunction

	function automatic logic num_body(input logic [7:0] c);
		return is_digit(c) || c == CH_UND;
	endfunction

	function automatic logic num_mark(input logic [7:0] c);
		return c == CH_DOT || c == CH_E || c == CH_UE;
	endfunction

	// Operator and punctuation lookup; unknown bytes give ERROR
	function automatic fix_t op_lookup(input logic [7:0] c, input logic [7:0] n1,
			input logic [7:0] n2);
		fix_t f;
		f.kind = TK_ERR;
		f.len = 3'd1;
		case (c)
			8'h28: f.kind = TK_LPAR;
			8'h29: f.kind = TK_RPAR;
			8'h5B: f.kind = TK_LBRK;
			8'h5D: f.kind = TK_RBRK;
			8'h7B: f.kind = TK_LBRC;
			8'h7D: f.kind = TK_RBRC;
			8'h2B: f.kind = TK_ADD;
			8'h2D: begin
				if (n1 == CH_GT) begin
					f.kind = TK_ARW;
					f.len = 3'd2;
				end else f.kind = TK_SUB;
			end
			CH_STAR: f.kind = TK_MUL;
			CH_SLASH: f.kind = TK_DIV;
			8'h23: f.kind = TK_HSH;
			8'h40: f.kind = TK_ATS;
			8'h7E: f.kind = TK_TLD;
			8'h21: begin
				if (n1 == CH_EQ) begin
					f.kind = TK_NE;
					f.len = 3'd2;
				end else f.kind = TK_BANG;
			end
			8'h3F: f.kind = TK_QM;
			8'h3A: f.kind = TK_COL;
			8'h3B: f.kind = TK_SEMI;
			8'h2C: f.kind = TK_CMA;
			CH_DOT: begin
				if (n1 == CH_DOT && n2 == CH_DOT) begin
					f.kind = TK_ELL;
					f.len = 3'd3;
				end else f.kind = TK_DOT;
			end
			8'h26: f.kind = TK_AMP;
			8'h7C: f.kind = TK_BAR;
			8'h5E: f.kind = TK_CRT;
			CH_EQ: begin
				if (n1 == CH_EQ) begin
					f.kind = TK_EQ;
					f.len = 3'd2;
				end else f.kind = TK_ASN;
			end
			CH_GT: begin
				if (n1 == CH_EQ) begin
					f.kind = TK_GE;
					f.len = 3'd2;
				end else if (n1 == CH_GT && n2 == CH_GT) begin
					f.kind = TK_ROR;
					f.len = 3'd3;
				end else if (n1 == CH_GT) begin
					f.kind = TK_SHR;
					f.len = 3'd2;
				end else f.kind = TK_GT;
			end
			CH_LT: begin
				if (n1 == CH_EQ) begin
					f.kind = TK_LE;
					f.len = 3'd2;
				end else if (n1 == CH_LT && n2 == CH_LT) begin
					f.kind = TK_ROL;
					f.len = 3'd3;
				end else if (n1 == CH_LT) begin
					f.kind = TK_SHL;
					f.len = 3'd2;
				end else f.kind = TK_LT;
			end
			default: f.kind = TK_ERR;
		endcase
		return f;
	endfunction

endpackage

// ----- sv/stl_core.sv -----
`timescale 1ns / 1ps
module stl_core import stl_pkg::*; #(
	parameter int COUNT_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  op_t        op,
	input  logic [7:0] c,
	input  logic [7:0] n1,
	input  logic [7:0] n2,
	input  logic [7:0] n3,
	output logic       push,
	output res_t       res
);

	localparam int W = COUNT_BITS;

	function automatic logic [W-1:0] sat_inc(input logic [W-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	mode_t mode_q, mode_n;
	logic [5:0] pk_q, pk_n;
	logic [W-1:0] ps_q, ps_n, pl_q, pl_n, pln_q, pln_n, pcol_q, pcol_n;
	logic [W-1:0] off_q, off_n, line_q, line_n, col_q, col_n, dep_q, dep_n, dep_dn;
	logic emit_p, fx_en;
	fix_t fx;

	// Examine one byte, or finish the text
	always_comb begin
		mode_n = mode_q;
		pk_n = pk_q;
		ps_n = ps_q;
		pl_n = pl_q;
		pln_n = pln_q;
		pcol_n = pcol_q;
		off_n = off_q;
		line_n = line_q;
		col_n = col_q;
		dep_n = dep_q;
		dep_dn = (dep_q != '0) ? dep_q - 1'b1 : dep_q;
		emit_p = 1'b0;
		fx_en = 1'b0;
		fx = '{kind: TK_ERR, len: 3'd1};
		push = 1'b0;
		res = '0;
		if (op == OP_STEP || op == OP_DRAIN) begin
			unique case (mode_q)
				M_SKIP3: mode_n = M_SKIP2;
				M_SKIP2: mode_n = M_SKIP1;
				M_SKIP1: mode_n = M_IDLE;
				M_BLOCK_SKIP: mode_n = M_BLOCK;
				M_LINE: if (c == CH_NL) mode_n = M_IDLE;
				M_BLOCK: begin
					if (c == CH_SLASH && n1 == CH_STAR) begin
						dep_n = sat_inc(dep_q);
						mode_n = M_BLOCK_SKIP;
					end else if (c == CH_STAR && n1 == CH_SLASH) begin
						dep_n = dep_dn;
						mode_n = (dep_dn == '0) ? M_SKIP1 : M_BLOCK_SKIP;
					end
				end
				M_IDENT: begin
					pl_n = sat_inc(pl_q);
					if (!ident_char(n1)) emit_p = 1'b1;
				end
				M_PREFIX, M_RADIX: begin
					pl_n = sat_inc(pl_q);
					if ((pk_q == TK_HEX) ? (is_xdigit(n1) || n1 == CH_UND)
							: (n1 == CH_ZERO || n1 == CH_ONE || n1 == CH_UND))
						mode_n = M_RADIX;
					else emit_p = 1'b1;
				end
				M_DEC: begin
					pl_n = sat_inc(pl_q);
					if (num_mark(n1)) mode_n = M_DEC_MARK;
					else if (num_body(n1)) mode_n = M_DEC;
					else emit_p = 1'b1;
				end
				M_DEC_MARK: begin
					pk_n = (c == CH_DOT) ? TK_FLT : TK_EXP;
					pl_n = sat_inc(pl_q);
					if (num_body(n1)) mode_n = M_DEC;
					else emit_p = 1'b1;
				end
				M_STRING: begin
					pl_n = sat_inc(pl_q);
					if (c == CH_DQ) emit_p = 1'b1;
				end
				default: begin
					mode_n = M_IDLE;
					if (is_space(c)) begin
						mode_n = M_IDLE;
					end else if (c == CH_SLASH && n1 == CH_SLASH) begin
						mode_n = M_LINE;
					end else if (c == CH_SLASH && n1 == CH_STAR) begin
						dep_n = {{(W-1){1'b0}}, 1'b1};
						mode_n = M_BLOCK_SKIP;
					end else if (is_alpha(c) || c == CH_UND) begin
						if (c == CH_UND && !is_alnum(n1)) begin
							fx_en = 1'b1;
							fx = '{kind: TK_UNDER, len: 3'd1};
						end else begin
							pk_n = TK_NAME;
							ps_n = off_q;
							pl_n = {{(W-1){1'b0}}, 1'b1};
							pln_n = line_q;
							pcol_n = col_q;
							if (ident_char(n1)) mode_n = M_IDENT;
							else emit_p = 1'b1;
						end
					end else if (is_digit(c)) begin
						ps_n = off_q;
						pl_n = {{(W-1){1'b0}}, 1'b1};
						pln_n = line_q;
						pcol_n = col_q;
						if (c == CH_ZERO && (n1 == CH_X || n1 == CH_B)) begin
							pk_n = (n1 == CH_X) ? TK_HEX : TK_BIN;
							mode_n = M_PREFIX;
						end else begin
							pk_n = TK_DEC;
							if (num_mark(n1)) mode_n = M_DEC_MARK;
							else if (num_body(n1)) mode_n = M_DEC;
							else emit_p = 1'b1;
						end
					end else if (c == CH_DQ) begin
						pk_n = TK_STR;
						ps_n = off_q;
						pl_n = {{(W-1){1'b0}}, 1'b1};
						pln_n = line_q;
						pcol_n = col_q;
						mode_n = M_STRING;
					end else if (c == CH_SQ) begin
						fx_en = 1'b1;
						if (n1 == CH_BSL && n2 != CH_NUL && n3 == CH_SQ)
							fx = '{kind: TK_CHR, len: 3'd4};
						else if (n1 != CH_NUL && n2 == CH_SQ)
							fx = '{kind: TK_CHR, len: 3'd3};
						else fx = '{kind: TK_ERR, len: 3'd1};
					end else begin
						fx_en = 1'b1;
						fx = op_lookup(c, n1, n2);
					end
				end
			endcase

			// Emit the pending token or a token at the current byte
			if (emit_p) begin
				push = 1'b1;
				mode_n = M_IDLE;
				res = '{kind: pk_n, start: 16'(ps_n), len: 16'(pl_n), line: 16'(pln_n),
					col: 16'(pcol_n), last: op == OP_STEP};
			end else if (fx_en) begin
				push = 1'b1;
				res = '{kind: fx.kind, start: 16'(off_q), len: 16'(fx.len),
					line: 16'(line_q), col: 16'(col_q), last: op == OP_STEP};
				case (fx.len)
					3'd2: mode_n = M_SKIP1;
					3'd3: mode_n = M_SKIP2;
					3'd4: mode_n = M_SKIP3;
					default: mode_n = M_IDLE;
				endcase
			end

			// Advance the position
			off_n = sat_inc(off_q);
			if (c == CH_NL) begin
				line_n = sat_inc(line_q);
				col_n = {{(W-1){1'b0}}, 1'b1};
			end else col_n = sat_inc(col_q);
		end else if (op == OP_TAIL) begin
			push = 1'b1;
			if (mode_q == M_STRING) begin
				mode_n = M_IDLE;
				res = '{kind: TK_ERR, start: 16'(ps_q), len: 16'(pl_q), line: 16'(pln_q),
					col: 16'(pcol_q), last: 1'b0};
			end else begin
				res = '{kind: TK_END, start: 16'(off_q), len: 16'd0, line: 16'(line_q),
					col: 16'(col_q), last: 1'b1};
				mode_n = M_IDLE;
				pk_n = '0;
				ps_n = '0;
				pl_n = '0;
				pln_n = {{(W-1){1'b0}}, 1'b1};
				pcol_n = {{(W-1){1'b0}}, 1'b1};
				off_n = '0;
				line_n = {{(W-1){1'b0}}, 1'b1};
				col_n = {{(W-1){1'b0}}, 1'b1};
				dep_n = '0;
			end
		end
	end

	// Hold lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			pk_q <= '0;
			ps_q <= '0;
			pl_q <= '0;
			pln_q <= {{(W-1){1'b0}}, 1'b1};
			pcol_q <= {{(W-1){1'b0}}, 1'b1};
			off_q <= '0;
			line_q <= {{(W-1){1'b0}}, 1'b1};
			col_q <= {{(W-1){1'b0}}, 1'b1};
			dep_q <= '0;
		end else begin
			mode_q <= mode_n;
			pk_q <= pk_n;
			ps_q <= ps_n;
			pl_q <= pl_n;
			pln_q <= pln_n;
			pcol_q <= pcol_n;
			off_q <= off_n;
			line_q <= line_n;
			col_q <= col_n;
			dep_q <= dep_n;
		end
	end

endmodule

// ----- sv/source_text_lexer.sv -----
`timescale 1ns / 1ps
// Streaming lexer: one byte of source text per beat in, tokens out.
// Input channel text_valid/text_ready carries text_byte; a zero byte ends
// the text. Output channel token_valid/token_ready carries one token per
// beat with kind, start offset, length, line, column and run_last, which
// marks the last token caused by one input byte.
// A byte is judged three bytes after it arrives (three bytes of lookahead),
// so a token that ends at a byte appears once the third byte after it is taken.
// Throughput: one byte per cycle while the queue has room and no flush runs.
// The lexer core then examines one byte a cycle and writes at most one token
// into a two-entry output queue, registered as its byte is examined.
// A zero byte starts a flush: each held byte is examined in turn, then an
// unterminated string gives ERROR, then STOP. Input is not taken meanwhile.
// Reset clears the window, the position (line and column 1) and the queue.
// When the receiver stalls, the queue fills and text_ready drops once two
// tokens wait; nothing is lost.
module source_text_lexer import stl_pkg::*; #(
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        text_valid,
	output logic        text_ready,
	input  logic [7:0]  text_byte,
	output logic        token_valid,
	input  logic        token_ready,
	output logic [5:0]  token_kind,
	output logic [15:0] token_start,
	output logic [15:0] token_length,
	output logic [15:0] token_line,
	output logic [15:0] token_column,
	output logic        run_last
);

	logic [7:0] w0_q, w1_q, w2_q;
	logic flush_q;
	logic [1:0] cnt_q;
	logic wp_q, rp_q;
	res_t fifo_q [2];
	logic room, acc, pop, push;
	op_t op;
	logic [7:0] c, n1, n2, n3;
	res_t res;

	assign room = cnt_q != 2'd2;
	assign text_ready = room && !flush_q;
	assign acc = text_valid && text_ready;
	assign pop = token_valid && token_ready;

	// Pick the core operation for this cycle
	always_comb begin
		op = OP_NONE;
		c = w0_q;
		n1 = w1_q;
		n2 = w2_q;
		n3 = text_byte;
		if (flush_q) begin
			n3 = CH_NUL;
			if (room) op = (w0_q != CH_NUL) ? OP_DRAIN : OP_TAIL;
		end else if (acc && text_byte != CH_NUL && w2_q != CH_NUL) begin
			op = OP_STEP;
		end
	end

	stl_core #(.COUNT_BITS(COUNT_BITS)) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.op(op),
		.c(c),
		.n1(n1),
		.n2(n2),
		.n3(n3),
		.push(push),
		.res(res)
	);

	// Advance the lookahead window and the flush sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w0_q <= CH_NUL;
			w1_q <= CH_NUL;
			w2_q <= CH_NUL;
			flush_q <= 1'b0;
		end else begin
			if (op == OP_DRAIN || op == OP_STEP) begin
				w0_q <= w1_q;
				w1_q <= w2_q;
				w2_q <= n3;
			end else if (op == OP_TAIL) begin
				if (res.last) flush_q <= 1'b0;
			end else if (acc) begin
				if (text_byte == CH_NUL) flush_q <= 1'b1;
				else if (w0_q == CH_NUL) w0_q <= text_byte;
				else if (w1_q == CH_NUL) w1_q <= text_byte;
				else w2_q <= text_byte;
			end
		end
	end

	// Output queue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wp_q <= 1'b0;
			rp_q <= 1'b0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// Output queue storage
	always_ff @(posedge clk) begin
		if (push) fifo_q[wp_q] <= res;
	end

	assign token_valid = cnt_q != 2'd0;
	assign token_kind = fifo_q[rp_q].kind;
	assign token_start = fifo_q[rp_q].start;
	assign token_length = fifo_q[rp_q].len;
	assign token_line = fifo_q[rp_q].line;
	assign token_column = fifo_q[rp_q].col;
	assign run_last = fifo_q[rp_q].last;

endmodule

// ----- sv/stl_checker.sv -----
`timescale 1ns / 1ps
`include "source_text_lexer_macros.svh"
module stl_checker import stl_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        text_valid,
	input logic        text_ready,
	input logic [7:0]  text_byte,
	input logic        token_valid,
	input logic        token_ready,
	input logic [5:0]  token_kind,
	input logic [15:0] token_start,
	input logic [15:0] token_length,
	input logic [15:0] token_line,
	input logic [15:0] token_column,
	input logic        run_last
);

	// A waiting token is not withdrawn
	`STL_ASSERT_NEXT(a_tok_hold, clk, arst_n, token_valid && !token_ready, token_valid, "token dropped while stalled")

	// STOP closes the run and has no length
	`STL_ASSERT(a_stop_shape, clk, arst_n, !(token_valid && token_kind == TK_END) || (run_last && token_length == 16'd0), "bad STOP token")

	// End of text blocks input while the held bytes drain
	`STL_ASSERT_NEXT(a_flush_block, clk, arst_n, text_valid && text_ready && text_byte == 8'h00, !text_ready, "input taken during flush")

endmodule

bind source_text_lexer stl_checker u_stl_checker (.*);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
	import stl_pkg::*;

	typedef struct {
		logic [5:0]  kind;
		logic [15:0] start;
		logic [15:0] len;
		logic [15:0] line;
		logic [15:0] col;
		logic        last;
	} token_s;

	// Token predictor and store of expected tokens
	class lex_board;
		logic [7:0]  win [3];
		mode_t       mode;
		logic [5:0]  pk;
		logic [15:0] ps, pl, pln, pcol;
		logic [15:0] offs, cur_line, cur_col, depth;
		token_s      tok_q [$];
		token_s      step_toks [$];
		int          errors;

		function new();
			errors = 0;
			clear_state();
		endfunction

		function void clear_state();
			win[0] = 0;
			win[1] = 0;
			win[2] = 0;
			mode = M_IDLE;
			pk = 0;
			ps = 0;
			pl = 0;
			pln = 1;
			pcol = 1;
			offs = 0;
			cur_line = 1;
			cur_col = 1;
			depth = 0;
		endfunction

		function logic [15:0] sat(logic [15:0] v);
			return (v == 16'hFFFF) ? v : v + 16'd1;
		endfunction

		function bit letter_c(logic [7:0] c);
			return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
		endfunction

		function bit digit_c(logic [7:0] c);
			return c >= "0" && c <= "9";
		endfunction

		function bit word_c(logic [7:0] c);
			return letter_c(c) || digit_c(c) || c == "_";
		endfunction

		function bit body_c(logic [7:0] c);
			return digit_c(c) || c == "_";
		endfunction

		function bit mark_c(logic [7:0] c);
			return c == "." || c == "e" || c == "E";
		endfunction

		function bit radix_c(logic [7:0] c);
			if (pk == TK_HEX)
				return digit_c(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F") ||
					c == "_";
			return c == "0" || c == "1" || c == "_";
		endfunction

		function void emit(logic [5:0] k, logic [15:0] st, logic [15:0] ln,
				logic [15:0] l, logic [15:0] c);
			token_s t;
			if (step_toks.size() >= 4) return;
			t.kind = k;
			t.start = st;
			t.len = ln;
			t.line = l;
			t.col = c;
			t.last = 0;
			step_toks.push_back(t);
		endfunction

		function void emit_here(logic [5:0] k, logic [15:0] ln);
			emit(k, offs, ln, cur_line, cur_col);
		endfunction

		function void flush_pending();
			emit(pk, ps, pl, pln, pcol);
			mode = M_IDLE;
		endfunction

		function void open_pending(logic [5:0] k);
			pk = k;
			ps = offs;
			pl = 1;
			pln = cur_line;
			pcol = cur_col;
		endfunction

		function void fixed_tok(logic [5:0] k, int ln);
			emit_here(k, 16'(ln));
			mode = (ln == 3) ? M_SKIP2 : (ln == 4) ? M_SKIP3 : (ln == 2) ? M_SKIP1 : M_IDLE;
		endfunction

		function void dec_follow(logic [7:0] n1);
			if (mark_c(n1)) mode = M_DEC_MARK;
			else if (body_c(n1)) mode = M_DEC;
			else flush_pending();
		endfunction

		function void idle_byte(logic [7:0] c, logic [7:0] n1, logic [7:0] n2,
				logic [7:0] n3);
			logic [5:0] k;
			int ln;
			k = TK_ERR;
			ln = 1;
			if (c == " " || (c >= 8'd9 && c <= 8'd13)) return;
			if (c == "/" && n1 == "/") begin
				mode = M_LINE;
				return;
			end
			if (c == "/" && n1 == "*") begin
				depth = 1;
				mode = M_BLOCK_SKIP;
				return;
			end
			if (letter_c(c) || c == "_") begin
				if (c == "_" && !(letter_c(n1) || digit_c(n1))) begin
					emit_here(TK_UNDER, 1);
					return;
				end
				open_pending(TK_NAME);
				if (word_c(n1)) mode = M_IDENT;
				else flush_pending();
				return;
			end
			if (digit_c(c)) begin
				if (c == "0" && (n1 == "x" || n1 == "b")) begin
					open_pending(n1 == "x" ? TK_HEX : TK_BIN);
					mode = M_PREFIX;
					return;
				end
				open_pending(TK_DEC);
				dec_follow(n1);
				return;
			end
			if (c == "\"") begin
				open_pending(TK_STR);
				mode = M_STRING;
				return;
			end
			if (c == "'") begin
				if (n1 == "\\" && n2 != 0 && n3 == "'") fixed_tok(TK_CHR, 4);
				else if (n1 != 0 && n2 == "'") fixed_tok(TK_CHR, 3);
				else fixed_tok(TK_ERR, 1);
				return;
			end
			case (c)
				"(": k = TK_LPAR;
				")": k = TK_RPAR;
				"[": k = TK_LBRK;
				"]": k = TK_RBRK;
				"{": k = TK_LBRC;
				"}": k = TK_RBRC;
				"+": k = TK_ADD;
				"-": begin
					if (n1 == ">") begin
						k = TK_ARW;
						ln = 2;
					end else k = TK_SUB;
				end
				"*": k = TK_MUL;
				"/": k = TK_DIV;
				"#": k = TK_HSH;
				"@": k = TK_ATS;
				"~": k = TK_TLD;
				"!": begin
					if (n1 == "=") begin
						k = TK_NE;
						ln = 2;
					end else k = TK_BANG;
				end
				"?": k = TK_QM;
				":": k = TK_COL;
				";": k = TK_SEMI;
				",": k = TK_CMA;
				".": begin
					if (n1 == "." && n2 == ".") begin
						k = TK_ELL;
						ln = 3;
					end else k = TK_DOT;
				end
				"&": k = TK_AMP;
				"|": k = TK_BAR;
				"^": k = TK_CRT;
				"=": begin
					if (n1 == "=") begin
						k = TK_EQ;
						ln = 2;
					end else k = TK_ASN;
				end
				">": begin
					if (n1 == "=") begin
						k = TK_GE;
						ln = 2;
					end else if (n1 == ">") begin
						k = (n2 == ">") ? TK_ROR : TK_SHR;
						ln = (n2 == ">") ? 3 : 2;
					end else k = TK_GT;
				end
				"<": begin
					if (n1 == "=") begin
						k = TK_LE;
						ln = 2;
					end else if (n1 == "<") begin
						k = (n2 == "<") ? TK_ROL : TK_SHL;
						ln = (n2 == "<") ? 3 : 2;
					end else k = TK_LT;
				end
				default: k = TK_ERR;
			endcase
			fixed_tok(k, ln);
		endfunction

		function void examine(logic [7:0] c, logic [7:0] n1, logic [7:0] n2,
				logic [7:0] n3);
			case (mode)
				M_SKIP3: mode = M_SKIP2;
				M_SKIP2: mode = M_SKIP1;
				M_SKIP1: mode = M_IDLE;
				M_BLOCK_SKIP: mode = M_BLOCK;
				M_LINE: if (c == "\n") mode = M_IDLE;
				M_BLOCK: begin
					if (c == "/" && n1 == "*") begin
						depth = sat(depth);
						mode = M_BLOCK_SKIP;
					end else if (c == "*" && n1 == "/") begin
						if (depth > 0) depth = depth - 1;
						mode = (depth == 0) ? M_SKIP1 : M_BLOCK_SKIP;
					end
				end
				M_IDENT: begin
					pl = sat(pl);
					if (!word_c(n1)) flush_pending();
				end
				M_PREFIX, M_RADIX: begin
					pl = sat(pl);
					if (radix_c(n1)) mode = M_RADIX;
					else flush_pending();
				end
				M_DEC: begin
					pl = sat(pl);
					dec_follow(n1);
				end
				M_DEC_MARK: begin
					pk = (c == ".") ? TK_FLT : TK_EXP;
					pl = sat(pl);
					if (body_c(n1)) mode = M_DEC;
					else flush_pending();
				end
				M_STRING: begin
					pl = sat(pl);
					if (c == "\"") flush_pending();
				end
				default: begin
					mode = M_IDLE;
					idle_byte(c, n1, n2, n3);
				end
			endcase
			offs = sat(offs);
			if (c == "\n") begin
				cur_line = sat(cur_line);
				cur_col = 1;
			end else cur_col = sat(cur_col);
		endfunction

		// Advance the predictor by one accepted byte and queue its tokens
		function void note_byte(logic [7:0] b);
			logic [7:0] a [6];
			step_toks.delete();
			if (b != 0) begin
				if (win[0] == 0) win[0] = b;
				else if (win[1] == 0) win[1] = b;
				else if (win[2] == 0) win[2] = b;
				else begin
					examine(win[0], win[1], win[2], b);
					win[0] = win[1];
					win[1] = win[2];
					win[2] = b;
				end
			end else begin
				a[0] = win[0];
				a[1] = win[1];
				a[2] = win[2];
				a[3] = 0;
				a[4] = 0;
				a[5] = 0;
				for (int i = 0; i < 3; i++) begin
					if (a[i] == 0) break;
					examine(a[i], a[i + 1], a[i + 2], a[i + 3]);
				end
				if (mode == M_STRING) begin
					pk = TK_ERR;
					flush_pending();
				end
				emit_here(TK_END, 0);
				clear_state();
			end
			if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1;
			foreach (step_toks[i]) tok_q.push_back(step_toks[i]);
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		// Compare one received token with the oldest expected one
		task check_token(token_s got);
			token_s want;
			if (tok_q.size() == 0) begin
				report($sformatf("unexpected token kind %0d", got.kind));
				return;
			end
			want = tok_q.pop_front();
			if (got.kind !== want.kind)
				report($sformatf("kind %0d, want %0d", got.kind, want.kind));
			if (got.start !== want.start)
				report($sformatf("start %0d, want %0d", got.start, want.start));
			if (got.len !== want.len)
				report($sformatf("length %0d, want %0d", got.len, want.len));
			if (got.line !== want.line)
				report($sformatf("line %0d, want %0d", got.line, want.line));
			if (got.col !== want.col)
				report($sformatf("column %0d, want %0d", got.col, want.col));
			if (got.last !== want.last)
				report($sformatf("run_last %0d, want %0d", got.last, want.last));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        text_valid;
	logic        text_ready;
	logic [7:0]  text_byte;
	logic        token_valid;
	logic        token_ready;
	logic [5:0]  token_kind;
	logic [15:0] token_start;
	logic [15:0] token_length;
	logic [15:0] token_line;
	logic [15:0] token_column;
	logic        run_last;

	lex_board board;
	int       cycles;
	int       hold_left;
	bit       quiet;
	int       sent;
	logic [7:0] text_q [$];

	source_text_lexer dut (
		.clk(clk),
		.arst_n(arst_n),
		.text_valid(text_valid),
		.text_ready(text_ready),
		.text_byte(text_byte),
		.token_valid(token_valid),
		.token_ready(token_ready),
		.token_kind(token_kind),
		.token_start(token_start),
		.token_length(token_length),
		.token_line(token_line),
		.token_column(token_column),
		.run_last(run_last)
	);

	initial clk = 0;
	always #5 clk = ~clk;

	// End the run if it hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 300000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Drive the receiver: long hold-off on request, otherwise random stalls unless quiet
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			token_ready <= 1'b0;
		end else token_ready <= quiet || ($urandom_range(0, 99) >= 9);
	end

	// Check every accepted token
	always @(posedge clk) begin
		token_s t;
		if (arst_n && token_valid && token_ready) begin
			t.kind = token_kind;
			t.start = token_start;
			t.len = token_length;
			t.line = token_line;
			t.col = token_column;
			t.last = run_last;
			board.check_token(t);
		end
	end

	// Offer one byte, with a random gap first unless quiet, and hold it until taken
	task automatic send_byte(input logic [7:0] b);
		@(negedge clk);
		while (!quiet && $urandom_range(0, 99) < 9) begin
			text_valid <= 1'b0;
			@(negedge clk);
		end
		text_valid <= 1'b1;
		text_byte <= b;
		do @(posedge clk); while (!text_ready);
		board.note_byte(b);
		sent++;
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
	endtask

	function automatic logic [7:0] pick(input string s);
		return s[$urandom_range(0, s.len() - 1)];
	endfunction

	// Append one well-formed fragment with random content, or noise
	task automatic add_fragment();
		string ops [] = '{"(", ")", "[", "]", "{", "}", "+", "->", "-", "*", "/", "#",
			"@", "~", "!=", "!", "?", ":", ";", ",", "...", ".", "&", "|", "^", "==",
			"=", ">=", ">>>", ">>", ">", "<=", "<<<", "<<", "<"};
		string alnum = "abcxyzABEZ019_";
		int n;
		n = $urandom_range(1, 6);
		case ($urandom_range(0, 11))
			0: begin
				text_q.push_back(pick("abqzAMZ_"));
				repeat (n - 1) text_q.push_back(pick(alnum));
			end
			1: begin
				text_q.push_back(pick("0123456789"));
				repeat (n - 1) text_q.push_back(pick("0123456789_.eE"));
			end
			2: begin
				add_text("0x");
				repeat (n) text_q.push_back(pick("09afAF_g"));
			end
			3: begin
				add_text("0b");
				repeat (n) text_q.push_back(pick("01_2"));
			end
			4: begin
				text_q.push_back("\"");
				repeat (n) text_q.push_back(pick("ab 1\n\\'+"));
				text_q.push_back("\"");
			end
			5: begin
				if ($urandom_range(0, 1)) begin
					text_q.push_back("'");
					text_q.push_back(pick("a\\' 9"));
					text_q.push_back("'");
				end else begin
					add_text("'\\");
					text_q.push_back(pick("n0'\\"));
					text_q.push_back("'");
				end
			end
			6: add_text(ops[$urandom_range(0, ops.size() - 1)]);
			7: begin
				add_text("//");
				repeat (n) text_q.push_back(pick("a /*\"x"));
				text_q.push_back("\n");
			end
			8: begin
				add_text("/*");
				if ($urandom_range(0, 1)) add_text(" /* a */");
				repeat (n) text_q.push_back(pick("b *\n/"));
				add_text("*/");
			end
			9: repeat (n) text_q.push_back(pick(" \t\n\r"));
			10: text_q.push_back(8'($urandom_range(1, 255)));
			default: text_q.push_back(" ");
		endcase
		if ($urandom_range(0, 2) == 0) text_q.push_back(pick(" \n"));
	endtask

	initial begin
		board = new();
		cycles = 0;
		hold_left = 0;
		quiet = 0;
		sent = 0;
		arst_n = 1'b0;
		text_valid = 1'b0;
		text_byte = 8'h00;
		token_ready = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: every token kind, comments, literals, open string at the end
		add_text("abc _ _x 0x1F 0b10 42 3.5 1e9 \"hi\" 'a' '\\n' ' ( ) [ ] { } + -> - ");
		add_text("* / # @ ~ != ! ? : ; , ... . & | ^ == = >= >>> >> > <= <<< << < $");
		add_text(" // c\n /* /* n */ */ x\n\xff\x80\"open");
		text_q.push_back(8'h00);
		text_q.push_back(8'h00);
		while (text_q.size() > 0) send_byte(text_q.pop_front());

		// Pause the sender until every expected token is in
		@(negedge clk);
		text_valid <= 1'b0;
		while (board.tok_q.size() > 0) @(posedge clk);

		// Random texts of fragments, ended by a zero byte
		while (sent < 380) begin
			repeat ($urandom_range(3, 12)) add_fragment();
			if ($urandom_range(0, 5) == 0) add_text("\"tail");
			text_q.push_back(8'h00);
			while (text_q.size() > 0) begin
				if (sent == 240) hold_left = 200;
				quiet = (sent >= 290 && sent < 360);
				send_byte(text_q.pop_front());
			end
		end
		quiet = 0;
		@(negedge clk);
		text_valid <= 1'b0;

		// Drain, then let the block settle
		while (board.tok_q.size() > 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (board.tok_q.size() > 0) board.report("tokens still expected at end");
		if (board.errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
